>>> rtl/core/mpi_pkg.sv
`default_nettype none

package mpi_pkg;

  // Profile codes held in the configuration register
  typedef enum logic [1:0] {
    MODE_ACCEL_DECEL = 2'd0,
    MODE_ACCEL       = 2'd1,
    MODE_DECEL       = 2'd2,
    MODE_LINEAR      = 2'd3
  } mode_e;

  localparam int unsigned POS_W   = 8;              // positions and distance
  localparam int unsigned FRM_W   = 16;             // frame index and count
  localparam int unsigned SQ_W    = 2 * FRM_W;      // squared frame terms
  localparam int unsigned K_W     = POS_W + 2;      // distance coefficients
  localparam int unsigned NUM_W   = K_W + SQ_W;     // scaled profile value
  localparam int unsigned DEN_W   = SQ_W + 1;       // 2 * count^2
  localparam int unsigned QUO_W   = POS_W;          // quotient never exceeds distance

  // Word that rides alongside the arithmetic to the final mirror step
  typedef struct packed {
    logic [POS_W-1:0] base;   // lower of the two positions
    logic [POS_W-1:0] span;   // absolute distance
    logic             swap;   // start above end: mirror the result
  } side_t;

endpackage

`default_nettype wire

>>> rtl/core/mpi_div.sv
`default_nettype none

// Restoring divider, one quotient bit per register stage, elastic handshake.
module mpi_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [mpi_pkg::NUM_W-1:0]   num_i,
  input  wire logic [mpi_pkg::DEN_W-1:0]   den_i,
  input  wire mpi_pkg::side_t              side_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [mpi_pkg::QUO_W-1:0]        quot_o,
  output logic                             rem_nz_o,
  output mpi_pkg::side_t                   side_o
);
  import mpi_pkg::*;

  logic [NUM_W-1:0] rem_q  [QUO_W];
  logic [DEN_W-1:0] den_q  [QUO_W];
  logic [QUO_W-1:0] quo_q  [QUO_W];
  side_t            side_q [QUO_W];
  logic [QUO_W-1:0] v_q;
  logic [QUO_W:0]   rdy;

  // A stage takes a word when empty or when the next one moves on
  assign rdy[QUO_W] = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int unsigned Sh = QUO_W - 1 - j;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    side_t            side_in;
    logic             v_in;
    logic [NUM_W-1:0] dsh;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign v_in    = in_valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign den_in  = den_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign side_in = side_q[j-1];
      assign v_in    = v_q[j-1];
    end

    assign rdy[j] = ~v_q[j] | rdy[j+1];

    // Trial subtract of the shifted divisor
    assign dsh = NUM_W'(den_in) << Sh;
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j]) begin
        rem_q[j]  <= ge ? (rem_in - dsh) : rem_in;
        den_q[j]  <= den_in;
        quo_q[j]  <= {quo_in[QUO_W-2:0], ge};
        side_q[j] <= side_in;
      end
    end
  end

  assign out_valid_o = v_q[QUO_W-1];
  assign quot_o      = quo_q[QUO_W-1];
  assign rem_nz_o    = |rem_q[QUO_W-1];
  assign side_o      = side_q[QUO_W-1];

endmodule

`default_nettype wire

>>> rtl/core/motion_profile_interpolator.sv
// Motion-profile interpolator for one servo.
// Input stream (s_axis): one word per request carrying start and end
// position, frame index and frame count. The index is clamped to the count
// and a count of zero is taken as one. Output stream (m_axis): one word per
// request with the interpolated position, floored to a byte and mirrored
// when start lies above end.
// The profile register (cfg_we_i / cfg_wdata_i) picks accel-decel,
// accelerate, decelerate or linear; write it only while the block is idle.
// Pipeline: four stages of clamp, squaring, coefficient products and the
// numerator sum, eight stages of the restoring divider (one quotient bit
// each), one output register.
// Throughput: one request per cycle, sustained while the receiver takes every word.
// Reset empties every stage and sets the profile to linear.
// When the receiver stalls, the output word holds and each stage keeps
// taking words until it is full, so requests are accepted until the whole
// pipeline is occupied; nothing is lost or repeated.
`default_nettype none

module motion_profile_interpolator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i,     // profile_mode
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [7:0] start_position, [15:8] end_position,
  // [31:16] frame_index, [47:32] frame_count
  input  wire logic [47:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o   // [7:0] position
);
  import mpi_pkg::*;

  mode_e mode_q;

  logic [POS_W-1:0] in_start, in_end, in_base, in_dist;
  logic [FRM_W-1:0] in_index, in_count, n_c, i_c, r_c;
  logic [POS_W-2:0] in_half;
  logic             in_swap;
  logic [K_W-1:0]   k1_d, k2_d;
  logic             sub_d;
  logic [FRM_W-1:0] xa_d, xb_d;
  logic [FRM_W:0]   i2_c;

  // stage 0: clamp and coefficients
  logic             v0_q;
  side_t            side0_q;
  logic [K_W-1:0]   k1_0_q, k2_0_q;
  logic             sub0_q;
  logic [FRM_W-1:0] n0_q, xa0_q, xb0_q;
  // stage 1: squares
  logic             v1_q;
  side_t            side1_q;
  logic [K_W-1:0]   k1_1_q, k2_1_q;
  logic             sub1_q;
  logic [SQ_W-1:0]  nn1_q, x1_q;
  // stage 2: scaled terms
  logic             v2_q;
  side_t            side2_q;
  logic             sub2_q;
  logic [NUM_W-1:0] t1_2_q, t2_2_q;
  logic [DEN_W-1:0] den2_q;
  // stage 3: numerator
  logic             v3_q;
  side_t            side3_q;
  logic [NUM_W-1:0] num3_q;
  logic [DEN_W-1:0] den3_q;
  // output stage
  logic             mv_q;
  logic [POS_W-1:0] pos_q, pos_d;

  logic             rdy0, rdy1, rdy2, rdy3, rdy_out;
  logic             div_in_ready, div_valid, div_nz;
  logic [QUO_W-1:0] div_quot;
  side_t            div_side;

  // Profile register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINEAR;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  // Ready chain, back from the output register
  assign rdy_out         = ~mv_q | m_axis_tready_i;
  assign rdy3            = ~v3_q | div_in_ready;
  assign rdy2            = ~v2_q | rdy3;
  assign rdy1            = ~v1_q | rdy2;
  assign rdy0            = ~v0_q | rdy1;
  assign s_axis_tready_o = rdy0;

  // Unpack, clamp the index and count, and order the two positions
  assign in_start = s_axis_tdata_i[7:0];
  assign in_end   = s_axis_tdata_i[15:8];
  assign in_index = s_axis_tdata_i[31:16];
  assign in_count = s_axis_tdata_i[47:32];
  assign n_c      = (in_count == '0) ? FRM_W'(1) : in_count;
  assign i_c      = (in_index > n_c) ? n_c : in_index;
  assign r_c      = n_c - i_c;
  assign i2_c     = {i_c, 1'b0};
  assign in_swap  = (in_start > in_end);
  assign in_base  = in_swap ? in_end : in_start;
  assign in_dist  = in_swap ? (in_start - in_end) : (in_end - in_start);
  assign in_half  = in_dist[POS_W-1:1];

  // Scaled value p = k1 * n^2 +/- k2 * xa * xb, over 2 * n^2
  always_comb begin
    k1_d  = '0;
    k2_d  = {1'b0, in_dist, 1'b0};
    sub_d = 1'b0;
    xa_d  = i_c;
    xb_d  = n_c;
    case (mode_q)
      MODE_ACCEL: begin
        xb_d = i_c;
      end
      MODE_DECEL: begin
        k1_d  = {1'b0, in_dist, 1'b0};
        sub_d = 1'b1;
        xa_d  = r_c;
        xb_d  = r_c;
      end
      MODE_ACCEL_DECEL: begin
        xb_d = i_c;
        if (i2_c < {1'b0, n_c}) begin
          k2_d = {in_half, 3'b000};
        end else if (i2_c > {1'b0, n_c}) begin
          k1_d  = K_W'({in_half, 1'b0}) + K_W'(in_dist);
          k2_d  = {in_half, 3'b000};
          sub_d = 1'b1;
          xa_d  = r_c;
          xb_d  = r_c;
        end else begin
          k1_d = K_W'({in_half, 1'b0});
          k2_d = '0;
        end
      end
      default: begin
        k2_d = {1'b0, in_dist, 1'b0};
      end
    endcase
  end

  // Valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= s_axis_tvalid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 0: capture clamped operands and coefficients
  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      side0_q <= '{base: in_base, span: in_dist, swap: in_swap};
      k1_0_q  <= k1_d;
      k2_0_q  <= k2_d;
      sub0_q  <= sub_d;
      n0_q    <= n_c;
      xa0_q   <= xa_d;
      xb0_q   <= xb_d;
    end
  end

  // Stage 1: count squared and the frame product
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      side1_q <= side0_q;
      k1_1_q  <= k1_0_q;
      k2_1_q  <= k2_0_q;
      sub1_q  <= sub0_q;
      nn1_q   <= n0_q * n0_q;
      x1_q    <= xa0_q * xb0_q;
    end
  end

  // Stage 2: scale both terms by the distance coefficients
  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      side2_q <= side1_q;
      sub2_q  <= sub1_q;
      t1_2_q  <= NUM_W'(k1_1_q) * NUM_W'(nn1_q);
      t2_2_q  <= NUM_W'(k2_1_q) * NUM_W'(x1_q);
      den2_q  <= {nn1_q, 1'b0};
    end
  end

  // Stage 3: combine into the numerator
  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      side3_q <= side2_q;
      num3_q  <= sub2_q ? (t1_2_q - t2_2_q) : (t1_2_q + t2_2_q);
      den3_q  <= den2_q;
    end
  end

  mpi_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .in_ready_o  (div_in_ready),
    .num_i       (num3_q),
    .den_i       (den3_q),
    .side_i      (side3_q),
    .out_valid_o (div_valid),
    .out_ready_i (rdy_out),
    .quot_o      (div_quot),
    .rem_nz_o    (div_nz),
    .side_o      (div_side)
  );

  // Floor from the lower end, or mirror with a ceiling from the upper end
  assign pos_d = div_side.swap
               ? (div_side.base + div_side.span - div_quot - POS_W'(div_nz))
               : (div_side.base + div_quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (rdy_out) begin
      mv_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      pos_q <= pos_d;
    end
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = pos_q;

endmodule

`default_nettype wire

>>> rtl/core/mpi_checker.sv
`default_nettype none

module mpi_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);

  // No word is offered once reset has been seen at an edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // Input back-pressure only ever comes from a stalled output word
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without an output stall");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("output word changed while stalled");

  // A full, stalled pipeline stays stalled until the receiver takes a word
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_axis_tready_o && !m_axis_tready_i) |=> (!s_axis_tready_o || m_axis_tready_i))
    else $error("input opened without an output transfer");

endmodule

bind motion_profile_interpolator mpi_checker u_mpi_checker (.*);

`default_nettype wire

>>> bench/tb_motion_profile_interpolator.sv
`timescale 1ns / 100ps

module tb_motion_profile_interpolator;
  import mpi_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_wdata_i = 2'd0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // [7:0] start_position, [15:8] end_position,
  // [31:16] frame_index, [47:32] frame_count
  logic [47:0] s_axis_tdata_i = 48'd0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;   // [7:0] position

  // Positions still owed by the block, oldest first
  logic [7:0]  expected_positions[$];
  mode_e       profile_now = MODE_LINEAR;
  int unsigned fault_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned recv_hold_cycles = 0;

  motion_profile_interpolator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Eased position, exact over the denominator 2 * count^2
  function automatic logic [7:0] predict_position(mode_e mode, logic [7:0] start_pos,
                                                  logic [7:0] end_pos, logic [15:0] idx,
                                                  logic [15:0] cnt);
    logic [63:0] n, i, nn, rem, span, half, scaled, den, pos;
    logic        mirror;
    n      = (cnt == 16'd0) ? 64'd1 : 64'(cnt);
    i      = (64'(idx) > n) ? n : 64'(idx);
    nn     = n * n;
    rem    = n - i;
    den    = 64'd2 * nn;
    mirror = start_pos > end_pos;
    span   = mirror ? 64'(start_pos - end_pos) : 64'(end_pos - start_pos);
    half   = span >> 1;
    case (mode)
      MODE_ACCEL_DECEL: begin
        if (64'd2 * i < n) begin
          scaled = 64'd8 * half * i * i;
        end else if (64'd2 * i > n) begin
          scaled = 64'd2 * half * nn + span * nn - 64'd8 * half * rem * rem;
        end else begin
          scaled = 64'd2 * half * nn;
        end
      end
      MODE_ACCEL: scaled = 64'd2 * span * i * i;
      MODE_DECEL: scaled = 64'd2 * (span * nn - span * rem * rem);
      default:    scaled = 64'd2 * span * i * n;
    endcase
    if (mirror) begin
      pos = 64'(end_pos) + (span * den - scaled) / den;
    end else begin
      pos = 64'(start_pos) + scaled / den;
    end
    return pos[7:0];
  endfunction

  // Offer one request word and hold it until the block takes it
  task automatic send_request(logic [7:0] start_pos, logic [7:0] end_pos,
                              logic [15:0] idx, logic [15:0] cnt);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {cnt, idx, end_pos, start_pos};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_positions.push_back(predict_position(profile_now, start_pos, end_pos, idx, cnt));
  endtask

  task automatic send_random_request();
    logic [7:0]  start_pos, end_pos;
    logic [15:0] idx, cnt;
    start_pos = 8'($urandom_range(255));
    end_pos   = 8'($urandom_range(255));
    if ($urandom_range(15) == 0) start_pos = $urandom_range(1) ? 8'hFF : 8'h00;
    if ($urandom_range(15) == 0) end_pos = $urandom_range(1) ? 8'hFF : 8'h00;
    case ($urandom_range(3))
      0:       cnt = 16'($urandom_range(65535));
      1:       cnt = 16'($urandom_range(16));
      2:       cnt = 16'($urandom_range(255));
      default: cnt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
    case ($urandom_range(5))
      0:       idx = 16'($urandom_range(65535));
      1:       idx = cnt >> 1;
      2:       idx = cnt;
      default: idx = 16'($urandom_range(int'(cnt)));
    endcase
    send_request(start_pos, end_pos, idx, cnt);
  endtask

  // Drain the pipeline, then write the profile register while idle
  task automatic write_profile(mode_e mode);
    s_axis_tvalid_i <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    profile_now = mode;
  endtask

  // Linear profile straight out of reset
  task automatic test_reset_profile();
    send_request(8'd0, 8'd255, 16'd1, 16'd3);
    send_request(8'd99, 8'd99, 16'd1, 16'd2);
  endtask

  // Extremes, zero count, clamped index, exact half and mirroring per profile
  task automatic test_directed_profiles();
    mode_e mode;
    for (int m = 0; m < 4; m++) begin
      mode = mode_e'(m);
      write_profile(mode);
      send_request(8'd10, 8'd245, 16'd7, 16'd0);
      send_request(8'd0, 8'd255, 16'd0, 16'hFFFF);
      send_request(8'd255, 8'd0, 16'hFFFF, 16'hFFFF);
      send_request(8'd255, 8'd0, 16'd40000, 16'd3);
      send_request(8'd17, 8'd200, 16'd2, 16'd4);
      send_request(8'd200, 8'd17, 16'd32767, 16'hFFFF);
    end
  endtask

  // Random requests under the given idling pattern and each profile
  task automatic test_random_requests(int unsigned send_pct, int unsigned recv_pct);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    for (int m = 0; m < 4; m++) begin
      write_profile(mode_e'(m));
      repeat (65) send_random_request();
    end
  endtask

  // Hold the receiver off long enough for the pipeline to fill and stall
  task automatic test_backpressure();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_profile(MODE_ACCEL_DECEL);
    recv_hold_cycles = 300;
    repeat (40) send_random_request();
  endtask

  // Receiver: check each accepted word and pick the next ready
  initial begin
    logic [7:0] want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_positions.size() == 0) begin
          $display("%0t: unexpected position word, expected none, got %0d",
                   $time, m_axis_tdata_o);
          fault_count++;
        end else begin
          want = expected_positions.pop_front();
          if (m_axis_tdata_o !== want) begin
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $time, want, m_axis_tdata_o);
            fault_count++;
          end
        end
      end
      if (recv_hold_cycles != 0) begin
        m_axis_tready_i <= 1'b0;
        recv_hold_cycles--;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Abort a run that hangs
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_profile();
    test_directed_profiles();
    test_random_requests(9, 51);
    test_random_requests(51, 9);
    test_random_requests(0, 0);
    test_backpressure();
    s_axis_tvalid_i <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
